// File: hw/rtl/hert_pkg.sv
// shared types and constants of the held event release table
`default_nettype none

package hert_pkg;

  localparam int unsigned TableDepthDef   = 64;
  localparam int unsigned CheckIntervalMs = 3;
  localparam int unsigned KeyW            = 64;
  localparam int unsigned HandleW         = 16;
  localparam int unsigned TimeW           = 32;
  localparam int unsigned SeqW            = 32;
  localparam int unsigned DelayW          = 16;
  localparam int unsigned LimitW          = 6;
  localparam int unsigned CfgIdxW         = 2;
  localparam int unsigned CfgDataW        = 16;

  localparam logic              EnabledRst  = 1'b1;
  localparam logic [DelayW-1:0] MaxDelayRst = 16'd667;
  localparam logic [LimitW-1:0] LimitRst    = 6'd63;

  // input commands
  typedef enum logic [1:0] {
    CMD_REG  = 2'd0,
    CMD_REL  = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // result reasons
  typedef enum logic [1:0] {
    RSN_ADMIT   = 2'd0,
    RSN_REFUSE  = 2'd1,
    RSN_RELEASE = 2'd2,
    RSN_EXPIRE  = 2'd3
  } reason_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLED   = 2'd0,
    CFG_MAX_DELAY = 2'd1,
    CFG_LIMIT     = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [KeyW-1:0]    key;
    logic               key_present;
    logic [HandleW-1:0] payload_handle;
    logic               from_syscall_source;
    logic               is_held_copy;
    logic [TimeW-1:0]   now_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         reason;
    logic [KeyW-1:0]    out_key;
    logic [HandleW-1:0] out_handle;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic              enabled;
    logic [DelayW-1:0] max_delay;
    logic [LimitW-1:0] queue_limit;
  } cfg_regs_t;

  // classified item from front to back
  typedef struct packed {
    cmd_e     op;
    in_item_t item;
  } job_t;

  // one table entry in memory
  typedef struct packed {
    logic [KeyW-1:0]    key;
    logic [HandleW-1:0] handle;
    logic [TimeW-1:0]   stamp;
    logic [SeqW-1:0]    seq;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

`default_nettype wire

// File: hw/rtl/hert_if.sv
// valid/ready channel interfaces of the held event release table
`default_nettype none

interface hert_in_if;
  import hert_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hert_out_if;
  import hert_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface hert_cfg_if;
  import hert_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/hert_ram.sv
// generic single write port ram with registered read
`default_nettype none

module hert_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hert_front.sv
// front end: accepts items, drops unused commands, queues the rest
`default_nettype none

module hert_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  hert_in_if.sink             in_i,
  output hert_pkg::job_t      job_o,
  output logic                job_valid_o,
  input  wire logic           job_ready_i
);
  import hert_pkg::*;

  job_t       fifo_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;
  job_t       job_new;

  // classify the incoming item
  always_comb begin
    job_new.op   = cmd_e'(in_i.data.cmd);
    job_new.item = in_i.data;
  end

  assign in_i.ready  = (count_q != 2'd2);
  assign push        = in_i.valid && in_i.ready && (job_new.op != CMD_NONE);
  assign job_valid_o = (count_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = fifo_q[rd_ptr_q];

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= job_new;
    end
  end

  // queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop) rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/hert_back.sv
// back end: admission, release and expiry scans over the entry table
`default_nettype none

module hert_back #(
  parameter int unsigned TABLE_DEPTH = hert_pkg::TableDepthDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire hert_pkg::job_t      job_i,
  input  wire logic                job_valid_i,
  output logic                     job_ready_o,
  input  wire hert_pkg::cfg_regs_t cfg_i,
  hert_out_if.source               out_o
);
  import hert_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned HW = (CW > LimitW) ? CW : LimitW;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_FLUSH  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  cmd_e   op_q, op_d;
  logic [KeyW-1:0]    key_q, key_d;
  logic [TimeW-1:0]   now_q, now_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               rd_vld_q, rd_vld_d;
  logic [AW-1:0]      rd_idx_q, rd_idx_d;
  logic               bf_q, bf_d;
  logic [AW-1:0]      bidx_q, bidx_d;
  logic [SeqW-1:0]    bage_q, bage_d;
  logic [KeyW-1:0]    bkey_q, bkey_d;
  logic [HandleW-1:0] bhandle_q, bhandle_d;
  logic [TimeW-1:0]   bstamp_q, bstamp_d;
  logic               pend_q, pend_d;
  logic [KeyW-1:0]    pkey_q, pkey_d;
  logic [HandleW-1:0] phandle_q, phandle_d;
  reason_e            preason_q, preason_d;
  logic [TABLE_DEPTH-1:0] valid_q, valid_d;
  logic [CW-1:0]      held_q, held_d;
  logic [SeqW-1:0]    seq_q, seq_d;
  logic [TimeW-1:0]   lastchk_q, lastchk_d;
  logic               ovq_q, ovq_d;
  out_item_t          od_q, od_d;

  logic          out_free, emit;
  out_item_t     edata;
  logic          we, re;
  logic [AW-1:0] raddr;
  entry_t        wentry, rentry;
  logic          free_found;
  logic [AW-1:0] free_idx;
  logic          admit_ok, hit, take;
  logic [SeqW-1:0] age;

  hert_ram #(
    .Width (EntryW),
    .Depth (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (free_idx),
    .wdata_i (wentry),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rentry)
  );

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = AW'(i);
      end
    end
  end

  assign admit_ok = cfg_i.enabled && job_i.item.key_present &&
                    job_i.item.from_syscall_source && !job_i.item.is_held_copy &&
                    (HW'(held_q) <= HW'(cfg_i.queue_limit)) && free_found;

  always_comb begin
    wentry.key    = job_i.item.key;
    wentry.handle = job_i.item.payload_handle;
    wentry.stamp  = job_i.item.now_ms;
    wentry.seq    = seq_q;
  end

  // scan compare on the entry read last cycle
  assign age  = seq_q - rentry.seq;
  assign hit  = rd_vld_q && valid_q[rd_idx_q] && ((op_q == CMD_TICK) || (rentry.key == key_q));
  assign take = bf_q && ((op_q == CMD_REL) ||
                         ((now_q - bstamp_q) > TimeW'(cfg_i.max_delay)));

  assign out_free    = !ovq_q || out_o.ready;
  assign out_o.valid = ovq_q;
  assign out_o.data  = od_q;
  assign raddr       = cnt_q[AW-1:0];

  // control sequencer
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    key_d     = key_q;
    now_d     = now_q;
    cnt_d     = cnt_q;
    bf_d      = bf_q;
    bidx_d    = bidx_q;
    bage_d    = bage_q;
    bkey_d    = bkey_q;
    bhandle_d = bhandle_q;
    bstamp_d  = bstamp_q;
    pend_d    = pend_q;
    pkey_d    = pkey_q;
    phandle_d = phandle_q;
    preason_d = preason_q;
    valid_d   = valid_q;
    held_d    = held_q;
    seq_d     = seq_q;
    lastchk_d = lastchk_q;
    job_ready_o = 1'b0;
    emit      = 1'b0;
    edata     = '0;
    we        = 1'b0;
    re        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          case (job_i.op)
            CMD_REG: begin
              if (out_free) begin
                job_ready_o      = 1'b1;
                emit             = 1'b1;
                edata.reason     = admit_ok ? RSN_ADMIT : RSN_REFUSE;
                edata.out_key    = job_i.item.key;
                edata.out_handle = job_i.item.payload_handle;
                edata.last       = 1'b1;
                if (admit_ok) begin
                  we                = 1'b1;
                  valid_d[free_idx] = 1'b1;
                  held_d            = held_q + CW'(1);
                  seq_d             = seq_q + SeqW'(1);
                end
              end
            end
            CMD_REL: begin
              job_ready_o = 1'b1;
              op_d        = job_i.op;
              key_d       = job_i.item.key;
              now_d       = job_i.item.now_ms;
              cnt_d       = '0;
              bf_d        = 1'b0;
              state_d     = ST_SCAN;
            end
            CMD_TICK: begin
              job_ready_o = 1'b1;
              if ((job_i.item.now_ms - lastchk_q) >= TimeW'(CheckIntervalMs)) begin
                lastchk_d = job_i.item.now_ms;
                op_d      = job_i.op;
                key_d     = job_i.item.key;
                now_d     = job_i.item.now_ms;
                cnt_d     = '0;
                bf_d      = 1'b0;
                state_d   = ST_SCAN;
              end
            end
            default: begin
              job_ready_o = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (cnt_q != CW'(TABLE_DEPTH)) begin
          re    = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end
        if (hit && (!bf_q || (age > bage_q))) begin
          bf_d      = 1'b1;
          bidx_d    = rd_idx_q;
          bage_d    = age;
          bkey_d    = rentry.key;
          bhandle_d = rentry.handle;
          bstamp_d  = rentry.stamp;
        end
        if (rd_vld_q && (rd_idx_q == AW'(TABLE_DEPTH - 1))) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (take) begin
          if (!pend_q || out_free) begin
            if (pend_q) begin
              emit             = 1'b1;
              edata.reason     = preason_q;
              edata.out_key    = pkey_q;
              edata.out_handle = phandle_q;
              edata.last       = 1'b0;
            end
            pend_d          = 1'b1;
            pkey_d          = bkey_q;
            phandle_d       = bhandle_q;
            preason_d       = (op_q == CMD_REL) ? RSN_RELEASE : RSN_EXPIRE;
            valid_d[bidx_q] = 1'b0;
            held_d          = held_q - CW'(1);
            cnt_d           = '0;
            bf_d            = 1'b0;
            state_d         = ST_SCAN;
          end
        end else if (pend_q) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          emit             = 1'b1;
          edata.reason     = preason_q;
          edata.out_key    = pkey_q;
          edata.out_handle = phandle_q;
          edata.last       = 1'b1;
          pend_d           = 1'b0;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    rd_vld_d = re;
    rd_idx_d = raddr;
    ovq_d    = emit ? 1'b1 : (out_o.ready ? 1'b0 : ovq_q);
    od_d     = emit ? edata : od_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rd_vld_q  <= 1'b0;
      pend_q    <= 1'b0;
      valid_q   <= '0;
      held_q    <= '0;
      seq_q     <= '0;
      lastchk_q <= '0;
      ovq_q     <= 1'b0;
      cnt_q     <= '0;
      bf_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= rd_vld_d;
      pend_q    <= pend_d;
      valid_q   <= valid_d;
      held_q    <= held_d;
      seq_q     <= seq_d;
      lastchk_q <= lastchk_d;
      ovq_q     <= ovq_d;
      cnt_q     <= cnt_d;
      bf_q      <= bf_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    now_q     <= now_d;
    rd_idx_q  <= rd_idx_d;
    bidx_q    <= bidx_d;
    bage_q    <= bage_d;
    bkey_q    <= bkey_d;
    bhandle_q <= bhandle_d;
    bstamp_q  <= bstamp_d;
    pkey_q    <= pkey_d;
    phandle_q <= phandle_d;
    preason_q <= preason_d;
    od_q      <= od_d;
  end

endmodule

`default_nettype wire

// File: hw/rtl/held_event_release_table_unit.sv
// top level of the held event release table
//
// Three valid/ready channels: in_i takes command items (register, key
// ready, tick), out_o gives result items, cfg_i writes the enable, the
// maximum delay and the queue limit registers.
// The front end queues up to two items; the back end executes one at a time.
// A register item gives its single result from the output register in the
// cycle after it is taken when the back end is idle.
// A key ready or tick item scans the whole entry memory once per released
// or expired entry, reading one entry per cycle, plus one final scan that
// finds nothing to take; the flush state then hands out the last result.
// A key ready item with no match holds the back end for one full scan, a
// tick that comes too early is taken without a scan; neither gives a result.
// Results go out through a single output register; when the receiver
// stalls, the back end waits and the queue in front fills, then in_i.ready
// drops. Configuration writes are taken in every cycle.
// Reset empties the table and the queue and loads the register defaults.
`default_nettype none

module held_event_release_table_unit #(
  parameter int unsigned TABLE_DEPTH = hert_pkg::TableDepthDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hert_in_if.sink   in_i,
  hert_out_if.source out_o,
  hert_cfg_if.sink  cfg_i
);
  import hert_pkg::*;

  job_t      job;
  logic      job_valid, job_ready;
  cfg_regs_t cfg_q;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled      <= EnabledRst;
      cfg_q.max_delay    <= MaxDelayRst;
      cfg_q.queue_limit  <= LimitRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.data.idx))
        CFG_ENABLED:   cfg_q.enabled      <= cfg_i.data.wdata[0];
        CFG_MAX_DELAY: cfg_q.max_delay    <= cfg_i.data.wdata[DelayW-1:0];
        CFG_LIMIT:     cfg_q.queue_limit  <= cfg_i.data.wdata[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  hert_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  hert_back #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .cfg_i       (cfg_q),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// File: hw/rtl/hert_checker.sv
// port level checks of the held event release table, bound to the top level
`default_nettype none

module hert_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid_i,
  input wire logic              out_ready_i,
  input wire logic [1:0]        out_reason_i,
  input wire logic [63:0]       out_key_i,
  input wire logic [15:0]       out_handle_i,
  input wire logic              out_last_i
);
  import hert_pkg::*;

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_reason_i) && $stable(out_key_i) &&
                                    $stable(out_handle_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // admission answers are always the only result of their item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_reason_i == RSN_ADMIT) || (out_reason_i == RSN_REFUSE))
    |-> out_last_i)
    else $error("admission result without last");

  // nothing is offered right out of reset
  assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_i)
    else $error("result offered at reset release");

endmodule

bind held_event_release_table_unit hert_checker u_hert_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_reason_i (out_o.data.reason),
  .out_key_i    (out_o.data.out_key),
  .out_handle_i (out_o.data.out_handle),
  .out_last_i   (out_o.data.last)
);

`default_nettype wire
